FILE: rtl/cbsp_pkg.sv
// Shared constants, payload types and helpers for the closed cubic B-spline path evaluator.
`default_nettype none

package cbsp_pkg;

   localparam int POINT_COUNT   = 10;
   localparam int SEGMENT_STEPS = 20;
   localparam int GROUP_COUNT   = 4;
   localparam int SPLINE_DEGREE = 3;
   localparam int SPL_ORDER     = SPLINE_DEGREE + 1;

   localparam int FX_SHIFT = 12;
   localparam int FX_ONE   = 1 << FX_SHIFT;

   localparam int PATH_LENGTH = SEGMENT_STEPS * POINT_COUNT + 1;
   localparam int STORE_DEPTH = GROUP_COUNT * POINT_COUNT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int MODE_W  = 1;
   localparam int GROUP_W = 2;
   localparam int IDX_W   = 4;
   localparam int COORD_W = 16;
   localparam int TIME_W  = 8;
   localparam int POS_W   = 24;
   localparam int POS_SHIFT = 8;

   localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;
   localparam logic [MODE_W-1:0] MODE_EVAL  = 1'b1;

   // Parameter u = (t << 12) / SEGMENT_STEPS by reciprocal multiplication.
   localparam int RECIP_SHIFT = 13;
   localparam int U_RECIP     = (FX_ONE * (1 << RECIP_SHIFT) + SEGMENT_STEPS - 1) / SEGMENT_STEPS;
   localparam int RECIP_W     = $clog2(U_RECIP + 1);
   localparam int U_PROD_W    = TIME_W + RECIP_W;
   localparam int U_RAW_W     = U_PROD_W - RECIP_SHIFT;
   localparam int U_MAX       = POINT_COUNT * FX_ONE;
   localparam int U_W         = $clog2(U_MAX + 1);
   localparam int CMP_W       = (U_RAW_W > U_W) ? U_RAW_W : U_W;
   localparam int LAST_KNOT   = (POINT_COUNT - 1) * FX_ONE;

   // Fraction within a span runs 0 to FX_ONE inclusive.
   localparam int F_W      = FX_SHIFT + 1;
   localparam int WEIGHT_W = F_W;
   localparam int V_W      = 15;
   localparam int DIV3_SHIFT = 16;
   localparam logic [V_W-1:0] DIV3_RECIP = V_W'(((1 << DIV3_SHIFT) + 2) / 3);

   localparam logic [F_W-1:0] ONE_FX   = F_W'(FX_ONE);
   localparam logic [F_W:0]   ONE_FX_X = (F_W + 1)'(FX_ONE);
   localparam logic [F_W:0]   TWO_FX_X = (F_W + 1)'(2 * FX_ONE);

   localparam int TERM_W = COORD_W + WEIGHT_W + 1 - FX_SHIFT;
   localparam int ACC_W  = TERM_W + $clog2(SPL_ORDER);
   localparam int J_W    = $clog2(SPL_ORDER);

   localparam int POS_HI = (1 << (POS_W - 1 - POS_SHIFT)) - 1;
   localparam int POS_LO = -(1 << (POS_W - 1 - POS_SHIFT));

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [GROUP_W-1:0]        path_group;
      logic [IDX_W-1:0]          point_index;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_z;
      logic [TIME_W-1:0]         path_time;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]       wrapped_time;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_z;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic           start;
      logic [F_W-1:0] frac;
   } basis_req_type;

   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [SPL_ORDER-1:0][WEIGHT_W-1:0] weight_set_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] s);
      logic signed [POS_W-1:0] r;
      if (s > $signed(ACC_W'(POS_HI))) begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end else if (s < $signed(ACC_W'(POS_LO))) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {s[POS_W-POS_SHIFT-1:0], {POS_SHIFT{1'b0}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/closed_cubic_bspline_path_eval.sv
// Closed uniform cubic B-spline path evaluator over four groups of ten control points.
//
// Input transfers on req_valid/req_ready carry one item. A write item (mode 0)
// stores one control point into the group memory in the transfer cycle and
// produces no result; a write to a slot or group outside the store is dropped.
// An evaluate item (mode 1) wraps its path time, finds the span and fraction,
// runs the basis weight pipeline and then reads the four points of the span from
// the control point memory, one per cycle, accumulating x and z.
// One result leaves on rsp_valid/rsp_ready for every evaluate item.
// An evaluate item holds the input from its transfer until its result is loaded
// into the output register: a setup step, the basis pipeline, a step to start
// reading, four memory reads through the single read port and a step to finish
// the sum.
// The output register lets an item finish while the receiver still holds the
// previous one; if the receiver stalls longer, the evaluation waits before
// loading its result and no new item is taken.
// Reset clears the sequencer and the output valid; the memory is not cleared,
// so each group must be written before it is evaluated.
`default_nettype none

module closed_cubic_bspline_path_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbsp_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = cbsp_pkg::IDX_W;
   localparam int ADDR_W = cbsp_pkg::ADDR_W;
   localparam int U_W    = cbsp_pkg::U_W;
   localparam int F_W    = cbsp_pkg::F_W;
   localparam int J_W    = cbsp_pkg::J_W;
   localparam int SUM_W  = IDX_W + 2;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BASIS = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_SUM   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [J_W-1:0] J_LAST = J_W'(cbsp_pkg::SPL_ORDER - 1);

   logic [2:0] state_ff, state_in;
   logic       req_fire, is_eval, store_we, wr_ok;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_eval   = (req_data.mode == cbsp_pkg::MODE_EVAL);
   assign wr_ok     = (32'(req_data.point_index) < cbsp_pkg::POINT_COUNT) &&
                      (32'(req_data.path_group) < cbsp_pkg::GROUP_COUNT);
   assign store_we  = req_fire && !is_eval && wr_ok;
   assign wr_addr   = ADDR_W'(32'(req_data.path_group) * cbsp_pkg::POINT_COUNT +
                              32'(req_data.point_index));

   // Time wrap, parameter and span selection for an incoming evaluate item.
   logic [cbsp_pkg::TIME_W-1:0]   t_wrap;
   logic [cbsp_pkg::U_PROD_W-1:0] u_prod;
   logic [cbsp_pkg::U_RAW_W-1:0]  u_raw;
   logic [U_W-1:0]                u_c;
   logic [IDX_W-1:0]              seg_in;
   logic [F_W-1:0]                frac_in;

   always_comb begin
      if (32'(req_data.path_time) >= cbsp_pkg::PATH_LENGTH) begin
         t_wrap = cbsp_pkg::TIME_W'(32'(req_data.path_time) - cbsp_pkg::PATH_LENGTH);
      end else begin
         t_wrap = req_data.path_time;
      end
      u_prod = cbsp_pkg::U_PROD_W'(t_wrap) * cbsp_pkg::U_PROD_W'(cbsp_pkg::U_RECIP);
      u_raw  = u_prod[cbsp_pkg::U_PROD_W-1:cbsp_pkg::RECIP_SHIFT];
      if (cbsp_pkg::CMP_W'(u_raw) > cbsp_pkg::CMP_W'(cbsp_pkg::U_MAX)) begin
         u_c = U_W'(cbsp_pkg::U_MAX);
      end else begin
         u_c = U_W'(u_raw);
      end
      // The last knot itself belongs to the last span.
      if (u_c >= U_W'(cbsp_pkg::LAST_KNOT)) begin
         seg_in  = IDX_W'(cbsp_pkg::POINT_COUNT - 1);
         frac_in = F_W'(u_c - U_W'(cbsp_pkg::LAST_KNOT));
      end else begin
         seg_in  = IDX_W'(u_c >> cbsp_pkg::FX_SHIFT);
         frac_in = {1'b0, u_c[cbsp_pkg::FX_SHIFT-1:0]};
      end
   end

   logic [cbsp_pkg::GROUP_W-1:0] grp_ff;
   logic [IDX_W-1:0]             seg_ff;
   logic [F_W-1:0]               frac_ff;
   logic [cbsp_pkg::TIME_W-1:0]  wtime_ff;
   logic                         bad_ff;
   logic                         start_ff, start_in;
   logic [J_W-1:0]               j_ff, j_in;
   logic                         rd_valid_ff;
   logic [J_W-1:0]               rd_j_ff;

   assign start_in = req_fire && is_eval;

   // Span point j maps onto the closed ring at (seg - 1 + j) mod POINT_COUNT.
   logic [SUM_W-1:0] ring_sum, ring_a, ring_b;
   logic [IDX_W-1:0] ring_idx;

   always_comb begin
      ring_sum = SUM_W'(seg_ff) + SUM_W'(cbsp_pkg::POINT_COUNT - 1) + SUM_W'(j_ff);
      ring_a   = (ring_sum >= SUM_W'(cbsp_pkg::POINT_COUNT)) ?
                 ring_sum - SUM_W'(cbsp_pkg::POINT_COUNT) : ring_sum;
      ring_b   = (ring_a >= SUM_W'(cbsp_pkg::POINT_COUNT)) ?
                 ring_a - SUM_W'(cbsp_pkg::POINT_COUNT) : ring_a;
      ring_idx = IDX_W'(ring_b);
   end

   assign rd_addr = ADDR_W'(32'(grp_ff) * cbsp_pkg::POINT_COUNT + 32'(ring_idx));

   cbsp_pkg::point_type wr_point, rd_point;
   assign wr_point.x = req_data.point_x;
   assign wr_point.z = req_data.point_z;

   cbsp_store u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (wr_addr),
      .wr_data (wr_point),
      .rd_addr (rd_addr),
      .rd_data (rd_point)
   );

   cbsp_pkg::basis_req_type  basis_req;
   cbsp_pkg::weight_set_type weights;
   logic                     basis_done;

   assign basis_req.start = start_ff;
   assign basis_req.frac  = frac_ff;

   cbsp_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .basis_req (basis_req),
      .weights   (weights),
      .done      (basis_done)
   );

   logic signed [cbsp_pkg::ACC_W-1:0] sum_x, sum_z;

   cbsp_accum u_accum (
      .clock  (clock),
      .clear  (start_in),
      .enable (rd_valid_ff),
      .point  (rd_point),
      .weight (weights[rd_j_ff]),
      .sum_x  (sum_x),
      .sum_z  (sum_z)
   );

   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   cbsp_pkg::rsp_type rsp_ff, rsp_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_in) begin
               state_in = ST_BASIS;
            end
         end
         ST_BASIS: begin
            if (basis_done) begin
               state_in = ST_READ;
               j_in     = '0;
            end
         end
         ST_READ: begin
            j_in = j_ff + 1'b1;
            if (j_ff == J_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in        = 1'b1;
         rsp_in.wrapped_time = wtime_ff;
         rsp_in.pos_x        = bad_ff ? '0 : cbsp_pkg::sat_pos(sum_x);
         rsp_in.pos_z        = bad_ff ? '0 : cbsp_pkg::sat_pos(sum_z);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rd_valid_ff  <= (state_ff == ST_READ);
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
      end
      rd_j_ff <= j_ff;
      rsp_ff  <= rsp_in;
      if (start_in) begin
         grp_ff   <= req_data.path_group;
         seg_ff   <= seg_in;
         frac_ff  <= frac_in;
         wtime_ff <= t_wrap;
         bad_ff   <= !(32'(req_data.path_group) < cbsp_pkg::GROUP_COUNT);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new result appears only as an evaluation finishes.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result became valid outside the finishing state");

   // The basis pipeline only completes while the sequencer waits for it.
   a_basis_in_wait: assert property (@(posedge clock) disable iff (reset)
      basis_done |-> (state_ff == ST_BASIS))
      else $error("basis weights completed outside the wait state");

   // Read data is only returned while the span points are being summed.
   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_READ || state_ff == ST_SUM))
      else $error("memory read data arrived outside the summing window");

   // Memory writes never overlap an evaluation's reads.
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !store_we)
      else $error("control point written during an evaluation");

endmodule

`default_nettype wire

FILE: rtl/cbsp_store.sv
// Control point memory: one write port, one registered read port.
`default_nettype none

module cbsp_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [cbsp_pkg::ADDR_W-1:0] wr_addr,
   input  cbsp_pkg::point_type         wr_data,
   input  logic [cbsp_pkg::ADDR_W-1:0] rd_addr,
   output cbsp_pkg::point_type         rd_data
);

   cbsp_pkg::point_type mem_ff [cbsp_pkg::STORE_DEPTH];
   cbsp_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/cbsp_basis.sv
// Three-stage pipeline for the four nonzero cubic basis weights of one span.
`default_nettype none

module cbsp_basis (
   input  logic                         clock,
   input  logic                         reset,
   input  cbsp_pkg::basis_req_type      basis_req,
   output cbsp_pkg::weight_set_type     weights,
   output logic                         done
);

   localparam int F_W = cbsp_pkg::F_W;
   localparam int V_W = cbsp_pkg::V_W;
   localparam int SH2 = cbsp_pkg::FX_SHIFT + 1;

   // Level two of the recurrence (divide by 2.0).
   logic [F_W-1:0]   f, g;
   logic [F_W:0]     g_p1, f_p1;
   logic [2*F_W-1:0] p_gg, p_ff;
   logic [2*F_W:0]   p_gf, p_fg;
   logic [F_W-1:0]   a0_in, a1_in, a2_in;
   logic [F_W-1:0]   a0_ff, a1_ff, a2_ff, f1_ff, g1_ff;
   logic             s1_valid_ff;

   assign f     = basis_req.frac;
   assign g     = cbsp_pkg::ONE_FX - f;
   assign g_p1  = {1'b0, g} + cbsp_pkg::ONE_FX_X;
   assign f_p1  = {1'b0, f} + cbsp_pkg::ONE_FX_X;
   assign p_gg  = g * g;
   assign p_ff  = f * f;
   assign p_gf  = g_p1 * f;
   assign p_fg  = f_p1 * g;
   assign a0_in = F_W'(p_gg >> SH2);
   assign a2_in = F_W'(p_ff >> SH2);
   assign a1_in = F_W'(p_gf >> SH2) + F_W'(p_fg >> SH2);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= basis_req.start;
      end
      a0_ff <= a0_in;
      a1_ff <= a1_in;
      a2_ff <= a2_in;
      f1_ff <= f;
      g1_ff <= g;
   end

   // Level three: each term is floored by 4096 here and then divided by three.
   logic [F_W:0]                    g1_p1, g1_p2, f1_p1, f1_p2;
   logic [5:0][2*F_W:0]             m;
   logic [5:0][V_W-1:0]             v_in;
   logic [5:0][V_W-1:0]             v_ff;
   logic                            s2_valid_ff;

   assign g1_p1 = {1'b0, g1_ff} + cbsp_pkg::ONE_FX_X;
   assign g1_p2 = {1'b0, g1_ff} + cbsp_pkg::TWO_FX_X;
   assign f1_p1 = {1'b0, f1_ff} + cbsp_pkg::ONE_FX_X;
   assign f1_p2 = {1'b0, f1_ff} + cbsp_pkg::TWO_FX_X;

   always_comb begin
      m[0] = (2*F_W+1)'(g1_ff * a0_ff);
      m[1] = g1_p1 * a1_ff;
      m[2] = f1_p2 * a0_ff;
      m[3] = g1_p2 * a2_ff;
      m[4] = f1_p1 * a1_ff;
      m[5] = (2*F_W+1)'(f1_ff * a2_ff);
      for (int i = 0; i < 6; i++) begin
         v_in[i] = V_W'(m[i] >> cbsp_pkg::FX_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      v_ff <= v_in;
   end

   logic [5:0][2*V_W-1:0]          n;
   logic [5:0][cbsp_pkg::WEIGHT_W-1:0] q;
   cbsp_pkg::weight_set_type       weights_in, weights_ff;
   logic                           done_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         n[i] = v_ff[i] * cbsp_pkg::DIV3_RECIP;
         q[i] = cbsp_pkg::WEIGHT_W'(n[i] >> cbsp_pkg::DIV3_SHIFT);
      end
      weights_in[0] = q[0];
      weights_in[1] = q[1] + q[2];
      weights_in[2] = q[3] + q[4];
      weights_in[3] = q[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         weights_ff <= weights_in;
      end
   end

   assign weights = weights_ff;
   assign done    = done_ff;

endmodule

`default_nettype wire

FILE: rtl/cbsp_accum.sv
// Weighted sum of control points, one point per cycle while enabled, with floored fixed-point terms.
`default_nettype none

module cbsp_accum (
   input  logic                                clock,
   input  logic                                clear,
   input  logic                                enable,
   input  cbsp_pkg::point_type                 point,
   input  cbsp_pkg::weight_type                weight,
   output logic signed [cbsp_pkg::ACC_W-1:0]   sum_x,
   output logic signed [cbsp_pkg::ACC_W-1:0]   sum_z
);

   localparam int PROD_W = cbsp_pkg::COORD_W + cbsp_pkg::WEIGHT_W + 1;
   localparam int ACC_W  = cbsp_pkg::ACC_W;

   logic signed [PROD_W-1:0]           prod_x, prod_z;
   logic signed [cbsp_pkg::TERM_W-1:0] term_x, term_z;
   logic signed [ACC_W-1:0]            acc_x_in, acc_z_in, acc_x_ff, acc_z_ff;

   assign prod_x = point.x * $signed({1'b0, weight});
   assign prod_z = point.z * $signed({1'b0, weight});
   // Dropping the low bits of a signed product floors toward minus infinity.
   assign term_x = prod_x[PROD_W-1:cbsp_pkg::FX_SHIFT];
   assign term_z = prod_z[PROD_W-1:cbsp_pkg::FX_SHIFT];

   always_comb begin
      acc_x_in = acc_x_ff;
      acc_z_in = acc_z_ff;
      if (clear) begin
         acc_x_in = '0;
         acc_z_in = '0;
      end else if (enable) begin
         acc_x_in = acc_x_ff + ACC_W'(term_x);
         acc_z_in = acc_z_ff + ACC_W'(term_z);
      end
   end

   always_ff @(posedge clock) begin
      acc_x_ff <= acc_x_in;
      acc_z_ff <= acc_z_in;
   end

   assign sum_x = acc_x_ff;
   assign sum_z = acc_z_ff;

endmodule

`default_nettype wire
